### design/direct_mapped_cache_tag_check_core_assert.svh
// Assertion macros shared by the cache tag check RTL.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_CORE_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define DCTC_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define DCTC_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define DCTC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dctc_pkg.sv
// Package with the fixed geometry and codes of the cache tag check.
package dctc_pkg;
	localparam int ADDR_W   = 32;
	localparam int NUM_SETS = 1024;
	localparam int SET_W    = $clog2(NUM_SETS);
	localparam int COUNT_W  = 32;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;
endpackage

### design/dctc_tag_store.sv
// Tag and valid memory with its clearing sweep and same-edge write forwarding.
module dctc_tag_store #(
	parameter int TAG_W = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     busy,
	input  logic                     rd_en,
	input  logic [dctc_pkg::SET_W-1:0] rd_set,
	input  logic                     wr_en,
	input  logic [dctc_pkg::SET_W-1:0] wr_set,
	input  logic [TAG_W-1:0]         wr_tag,
	output logic                     entry_valid,
	output logic [TAG_W-1:0]         entry_tag
);
	import dctc_pkg::*;

	logic [TAG_W:0]     mem [NUM_SETS];
	logic [TAG_W:0]     rd_data_s2;
	logic               byp_s2;
	logic [TAG_W-1:0]   byp_tag_s2;
	logic               clr_q;
	logic [SET_W-1:0]   clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SET_W'(NUM_SETS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_set] <= {1'b1, wr_tag};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s2 <= mem[rd_set];
			byp_tag_s2 <= wr_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s2 <= 1'b0;
		end else if (rd_en) begin
			byp_s2 <= wr_en && (wr_set == rd_set);
		end
	end

	assign busy        = clr_q;
	assign entry_valid = byp_s2 ? 1'b1 : rd_data_s2[TAG_W];
	assign entry_tag   = byp_s2 ? byp_tag_s2 : rd_data_s2[TAG_W-1:0];
endmodule

### design/direct_mapped_cache_tag_check_core.sv
// Top level of the direct-mapped cache tag check with hit and access counters.
//
//   channel  direction  handshake            words
//   in       into core  in_valid / in_ready  kind, address
//   out      from core  out_valid/out_ready  hit, reads_seen, read_hit_total,
//                                            writes_seen, write_hit_total
//
// One access per cycle while in_ready is high; each result leaves the second
// stage into the output register. The set memory is read at acceptance and
// written back on a miss as the access leaves the second stage, with the write
// forwarded to an access that reads the same set then. After reset a sweep clears
// the valid marks, one set per cycle across all 1024 sets, and in_ready stays low
// until it ends. A stalled result holds the pending access in the second stage.
`include "direct_mapped_cache_tag_check_core_assert.svh"

module direct_mapped_cache_tag_check_core #(
	parameter int OFFSET_BITS = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [dctc_pkg::ADDR_W-1:0]  address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [dctc_pkg::COUNT_W-1:0] reads_seen,
	output logic [dctc_pkg::COUNT_W-1:0] read_hit_total,
	output logic [dctc_pkg::COUNT_W-1:0] writes_seen,
	output logic [dctc_pkg::COUNT_W-1:0] write_hit_total
);
	import dctc_pkg::*;

	localparam int TAG_W = ADDR_W - OFFSET_BITS - SET_W;

	logic               busy;
	logic               in_acc;
	logic               adv;
	logic               lookup_hit;
	logic               entry_valid;
	logic [TAG_W-1:0]   entry_tag;
	logic [SET_W-1:0]   in_set;
	logic               valid_s2;
	logic               kind_s2;
	logic [SET_W-1:0]   set_s2;
	logic [TAG_W-1:0]   tag_s2;
	logic               out_valid_q;
	logic               hit_q;
	logic [COUNT_W-1:0] rd_cnt_q;
	logic [COUNT_W-1:0] rd_hit_cnt_q;
	logic [COUNT_W-1:0] wr_cnt_q;
	logic [COUNT_W-1:0] wr_hit_cnt_q;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	assign in_set     = address[OFFSET_BITS +: SET_W];
	assign adv        = valid_s2 && (!out_valid_q || out_ready);
	assign in_ready   = !busy && (!valid_s2 || adv);
	assign in_acc     = in_valid && in_ready;
	assign lookup_hit = entry_valid && (entry_tag == tag_s2);

	dctc_tag_store #(
		.TAG_W(TAG_W)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.busy        (busy),
		.rd_en       (in_acc),
		.rd_set      (in_set),
		.wr_en       (adv && !lookup_hit),
		.wr_set      (set_s2),
		.wr_tag      (tag_s2),
		.entry_valid (entry_valid),
		.entry_tag   (entry_tag)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s2 <= kind;
			set_s2  <= in_set;
			tag_s2  <= address[ADDR_W-1 -: TAG_W];
		end
		if (adv) begin
			hit_q <= lookup_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
			rd_cnt_q     <= '0;
			rd_hit_cnt_q <= '0;
			wr_cnt_q     <= '0;
			wr_hit_cnt_q <= '0;
		end else begin
			if (in_acc) begin
				valid_s2 <= 1'b1;
			end else if (adv) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (kind_s2 == KIND_WRITE) begin
					wr_cnt_q <= sat_inc(wr_cnt_q);
					if (lookup_hit) begin
						wr_hit_cnt_q <= sat_inc(wr_hit_cnt_q);
					end
				end else begin
					rd_cnt_q <= sat_inc(rd_cnt_q);
					if (lookup_hit) begin
						rd_hit_cnt_q <= sat_inc(rd_hit_cnt_q);
					end
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign reads_seen      = rd_cnt_q;
	assign read_hit_total  = rd_hit_cnt_q;
	assign writes_seen     = wr_cnt_q;
	assign write_hit_total = wr_hit_cnt_q;

	`DCTC_IMPLY(a_no_accept_in_sweep, busy, !in_ready, "access accepted during clearing sweep")
	`DCTC_ALWAYS(a_read_hits_bounded, rd_hit_cnt_q <= rd_cnt_q, "read hits exceed reads")
	`DCTC_ALWAYS(a_write_hits_bounded, wr_hit_cnt_q <= wr_cnt_q, "write hits exceed writes")
	`DCTC_NEXT(a_reads_monotonic, 1'b1, rd_cnt_q >= $past(rd_cnt_q), "read count decreased")
	`DCTC_NEXT(a_result_follows_lookup, adv, out_valid_q, "completed lookup gave no result")
endmodule
